### src/imadec_pkg.sv
// ----------------------------------------------------------------------------
// imadec_pkg
// Shared types, constants and tables of the IMA ADPCM block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package imadec_pkg;

	localparam int unsigned IDX_W   = 7;
	localparam int unsigned STEP_W  = 15;
	localparam int unsigned CNT_W   = 24;
	localparam int unsigned NIBBLES = 8;

	localparam logic [IDX_W-1:0] IDX_MAX  = 7'd88;
	localparam logic signed [15:0] PRED_MAX = 16'sd32767;
	localparam logic signed [15:0] PRED_MIN = -16'sd32768;

	// item opcodes
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA   = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [15:0] header_sample;
		logic [7:0]         header_index;
		logic [31:0]        data_word;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               run_last;
		logic               stream_last;
	} out_item_t;

	// decoder state carried between nibbles
	typedef struct packed {
		logic signed [15:0] pred;
		logic [IDX_W-1:0]   idx;
	} dec_state_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// quantiser step size for a step index
	function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
		logic [STEP_W-1:0] s;
		case (idx)
			7'd0: s = 15'd7;      7'd1: s = 15'd8;      7'd2: s = 15'd9;
			7'd3: s = 15'd10;     7'd4: s = 15'd11;     7'd5: s = 15'd12;
			7'd6: s = 15'd13;     7'd7: s = 15'd14;     7'd8: s = 15'd16;
			7'd9: s = 15'd17;     7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
			7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
			7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
			7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
			7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
			7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
			7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
			7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
			7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
			7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
			7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
			7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
			7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

	// step index adjustment for the magnitude bits of a code
	function automatic logic signed [4:0] index_adj(input logic [2:0] mag);
		logic signed [4:0] a;
		case (mag)
			3'd4: a = 5'sd2;
			3'd5: a = 5'sd4;
			3'd6: a = 5'sd6;
			3'd7: a = 5'sd8;
			default: a = -5'sd1;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

### src/ima_adpcm_block_decoder.sv
// ----------------------------------------------------------------------------
// ima_adpcm_block_decoder
// Mono IMA ADPCM decoder: header items load the predictor, data items carry
// eight codes that are shifted out one nibble per cycle, while the output is not stalled, and decoded.
//
//   channel  | signals                        | moves
//   ---------+--------------------------------+--------------------------
//   input    | in_valid, in_ready, in_data    | header or data word item
//   output   | out_valid, out_ready, out_data | one decoded sample item
//   config   | cfg_we, cfg_wdata              | total sample count
//
// A header item is accepted in the idle state and its sample is emitted from
// the run state; a data word is accepted and then decoded nibble by nibble,
// up to eight, by the single nibble decoder that the word shifts through.
// Items arriving after the end of the stream are accepted and dropped.
// A full output register that is not taken stalls the nibble shifting.
// Reset clears control state; samples_left resets to one.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_block_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [imadec_pkg::CNT_W-1:0]    cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire imadec_pkg::in_item_t            in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output imadec_pkg::out_item_t                out_data
);

	imadec_pkg::state_t             state_q, state_d;
	imadec_pkg::dec_state_t         dec_q, dec_nxt;
	logic [31:0]                    word_q;
	logic [2:0]                     nib_q;
	logic                           hdr_q;
	logic [imadec_pkg::CNT_W-1:0]   samples_left_q;
	logic                           finished_q;
	logic                           out_valid_q;
	imadec_pkg::out_item_t          out_q;
	logic                           accept;
	logic                           fire;
	logic                           ends;
	logic                           run_last;

	imadec_nibble u_nibble (
		.code (word_q[3:0]),
		.cur  (dec_q),
		.nxt  (dec_nxt)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imadec_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		fire     = 1'b0;
		case (state_q)
			imadec_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !finished_q) begin
					state_d = imadec_pkg::ST_RUN;
				end
			end
			imadec_pkg::ST_RUN: begin
				fire = !out_valid_q || out_ready;
				if (fire && run_last) begin
					state_d = imadec_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imadec_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept   = in_valid && in_ready && !finished_q;
	assign ends     = (samples_left_q <= imadec_pkg::CNT_W'(1));
	assign run_last = hdr_q || ends || (nib_q == 3'(imadec_pkg::NIBBLES - 1));

	// stream count and end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_left_q <= imadec_pkg::CNT_W'(1);
			finished_q     <= 1'b0;
		end else if (cfg_we) begin
			samples_left_q <= cfg_wdata;
			finished_q     <= 1'b0;
		end else if (fire) begin
			if (ends) begin
				samples_left_q <= '0;
				finished_q     <= 1'b1;
			end else begin
				samples_left_q <= samples_left_q - imadec_pkg::CNT_W'(1);
			end
		end
	end

	// predictor and step index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= '0;
		end else if (accept && (in_data.op == imadec_pkg::OP_HEADER)) begin
			dec_q.pred <= in_data.header_sample;
			if (in_data.header_index > 8'(imadec_pkg::IDX_MAX)) begin
				dec_q.idx <= imadec_pkg::IDX_MAX;
			end else begin
				dec_q.idx <= in_data.header_index[imadec_pkg::IDX_W-1:0];
			end
		end else if (fire && !hdr_q) begin
			dec_q <= dec_nxt;
		end
	end

	// code shift register, one nibble per decoded sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= 1'b0;
			nib_q <= '0;
		end else if (accept) begin
			hdr_q <= (in_data.op == imadec_pkg::OP_HEADER);
			nib_q <= '0;
		end else if (fire) begin
			nib_q <= nib_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= in_data.data_word;
		end else if (fire) begin
			word_q <= {4'h0, word_q[31:4]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.sample      <= hdr_q ? dec_q.pred : dec_nxt.pred;
			out_q.run_last    <= run_last;
			out_q.stream_last <= ends;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

### src/imadec_nibble.sv
// ----------------------------------------------------------------------------
// imadec_nibble
// Decodes one 4-bit code: difference from the step size, predictor update
// with clamping, and step index update with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module imadec_nibble (
	input  wire logic [3:0]              code,
	input  wire imadec_pkg::dec_state_t  cur,
	output imadec_pkg::dec_state_t       nxt
);

	logic [imadec_pkg::STEP_W-1:0]    step;
	logic [imadec_pkg::STEP_W+3:0]    prod;
	logic [15:0]                      diff;
	logic signed [17:0]               sum;
	logic signed [8:0]                ni;

	// exact difference ((mag*2+1)*step)>>3
	always_comb begin
		step = imadec_pkg::step_size(cur.idx);
		prod = {code[2:0], 1'b1} * step;
		diff = prod[imadec_pkg::STEP_W+3:3];
	end

	// predictor update, sign from the top bit of the code
	always_comb begin
		if (code[3]) begin
			sum = {{2{cur.pred[15]}}, cur.pred} - $signed({2'b00, diff});
		end else begin
			sum = {{2{cur.pred[15]}}, cur.pred} + $signed({2'b00, diff});
		end
		if (sum > 18'(imadec_pkg::PRED_MAX)) begin
			nxt.pred = imadec_pkg::PRED_MAX;
		end else if (sum < 18'(imadec_pkg::PRED_MIN)) begin
			nxt.pred = imadec_pkg::PRED_MIN;
		end else begin
			nxt.pred = sum[15:0];
		end
	end

	// step index update clamped to the table range
	always_comb begin
		ni = $signed({2'b00, cur.idx}) +
			9'(imadec_pkg::index_adj(code[2:0]));
		if (ni < 9'sd0) begin
			nxt.idx = '0;
		end else if (ni > $signed({2'b00, imadec_pkg::IDX_MAX})) begin
			nxt.idx = imadec_pkg::IDX_MAX;
		end else begin
			nxt.idx = ni[imadec_pkg::IDX_W-1:0];
		end
	end

endmodule

`default_nettype wire

### tb/imadec_checker.sv
// ----------------------------------------------------------------------------
// imadec_checker
// Watches the configuration, input and output channels of the IMA ADPCM
// block decoder. It keeps its own copy of the decoder state, works out the
// samples that each accepted item should produce and compares every sample
// taken from the output with the oldest one still outstanding.
// ----------------------------------------------------------------------------

module imadec_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [imadec_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  imadec_pkg::in_item_t             in_data,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  imadec_pkg::out_item_t            out_data,
	output int                               errors,
	output int                               pending
);

	timeunit 1ns;
	timeprecision 1ps;

	// quantiser step for each step index
	logic [14:0] step_lut [0:88] = '{
		15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
		15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
		15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
		15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
		15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
		15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
		15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
		15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
		15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
		15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
		15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
		15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
		15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
		15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
		15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
	};

	// mirrored decoder state
	logic [imadec_pkg::CNT_W-1:0]   samples_left;
	logic signed [15:0]             pred;
	logic [imadec_pkg::IDX_W-1:0]   idx;
	logic                           stream_done;

	imadec_pkg::out_item_t expected_samples [$];

	// one more sample of the stream; high when it completes the count
	function automatic logic count_one_sample();
		if (samples_left <= 1) begin
			samples_left = '0;
			stream_done  = 1'b1;
			return 1'b1;
		end
		samples_left = samples_left - 1'b1;
		return 1'b0;
	endfunction

	// samples that one accepted item produces
	task automatic decode_item(input imadec_pkg::in_item_t it);
		imadec_pkg::out_item_t r;
		logic [3:0]  code;
		logic        last;
		int          diff;
		int          p;
		int          ni;
		if (stream_done)
			return;
		if (it.op == imadec_pkg::OP_HEADER) begin
			pred = it.header_sample;
			idx  = (it.header_index > 8'd88) ? imadec_pkg::IDX_MAX
				: it.header_index[imadec_pkg::IDX_W-1:0];
			last = count_one_sample();
			r.sample      = pred;
			r.run_last    = 1'b1;
			r.stream_last = last;
			expected_samples.push_back(r);
		end else begin
			for (int i = 0; i < imadec_pkg::NIBBLES; i++) begin
				code = it.data_word[4*i +: 4];
				diff = ((int'(code[2:0]) * 2 + 1) * int'(step_lut[idx])) >>> 3;
				if (code[3])
					diff = -diff;
				p = int'(pred) + diff;
				if (p < -32768)
					p = -32768;
				if (p > 32767)
					p = 32767;
				pred = p[15:0];
				// small codes walk the index down, large ones up
				ni = int'(idx) + ((code[2:0] < 3'd4) ? -1 : (int'(code[2:0]) - 3) * 2);
				if (ni < 0)
					ni = 0;
				if (ni > 88)
					ni = 88;
				idx  = ni[imadec_pkg::IDX_W-1:0];
				last = count_one_sample();
				r.sample      = pred;
				r.run_last    = last || (i == imadec_pkg::NIBBLES - 1);
				r.stream_last = last;
				expected_samples.push_back(r);
				if (last)
					break;
			end
		end
	endtask

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		imadec_pkg::out_item_t exp_item;
		if (!arst_n) begin
			samples_left = 24'd1;
			pred         = '0;
			idx          = '0;
			stream_done  = 1'b0;
			expected_samples.delete();
		end else begin
			// register write starts a new stream
			if (cfg_we) begin
				samples_left = cfg_wdata;
				stream_done  = 1'b0;
			end

			// compare the sample taken at this edge
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$error("unexpected sample item: sample %0d run_last %0b stream_last %0b",
						out_data.sample, out_data.run_last, out_data.stream_last);
					errors++;
				end else begin
					exp_item = expected_samples.pop_front();
					if (out_data.sample !== exp_item.sample) begin
						$error("sample: expected %0d, actual %0d",
							exp_item.sample, out_data.sample);
						errors++;
					end
					if (out_data.run_last !== exp_item.run_last) begin
						$error("run_last: expected %0b, actual %0b",
							exp_item.run_last, out_data.run_last);
						errors++;
					end
					if (out_data.stream_last !== exp_item.stream_last) begin
						$error("stream_last: expected %0b, actual %0b",
							exp_item.stream_last, out_data.stream_last);
						errors++;
					end
				end
			end

			// predict the samples of an accepted item
			if (in_valid && in_ready)
				decode_item(in_data);
		end
		pending = expected_samples.size();
	end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the IMA ADPCM block decoder: a directed run over the extreme
// headers and codes, the end of the stream inside a word and the items after
// it, then random streams under several sample counts, with bursty input and
// a stalling output. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS  = 85;
	localparam int SETTLE_CYCLES = 20;
	localparam int IDLE_LIMIT    = 2000;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [imadec_pkg::CNT_W-1:0]   cfg_wdata = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	imadec_pkg::in_item_t           in_data   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	imadec_pkg::out_item_t          out_data;

	int errors;
	int pending;
	int burst_left  = 0;
	int ready_hold  = 0;
	int idle_cycles = 0;

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ima_adpcm_block_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	imadec_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	// receiver: long ready stretches broken by short and long stalls
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (out_ready) begin
			out_ready  <= 1'b0;
			ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16)
				: $urandom_range(0, 3);
		end else begin
			out_ready  <= 1'b1;
			ready_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 8);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("ima_adpcm_block_decoder test failed");
				$finish;
			end
		end
	end

	function automatic imadec_pkg::in_item_t header_item(input logic [15:0] s,
		input logic [7:0] hidx);
		imadec_pkg::in_item_t it;
		it.op            = imadec_pkg::OP_HEADER;
		it.header_sample = s;
		it.header_index  = hidx;
		it.data_word     = $urandom;
		return it;
	endfunction

	function automatic imadec_pkg::in_item_t data_item(input logic [31:0] w);
		imadec_pkg::in_item_t it;
		it.op            = imadec_pkg::OP_DATA;
		it.header_sample = 16'($urandom);
		it.header_index  = 8'($urandom);
		it.data_word     = w;
		return it;
	endfunction

	// random word, sometimes biased to push the index up or down
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 3))
			0:       return $urandom | 32'h44444444;
			1:       return $urandom & 32'hBBBBBBBB;
			default: return $urandom;
		endcase
	endfunction

	// offer one item, opening a new burst after a random gap when due
	task automatic send_item(input imadec_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	// hold the input until every outstanding sample has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// new stream length, written only once the decoder has gone quiet
	task automatic load_sample_count(input logic [imadec_pkg::CNT_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		imadec_pkg::in_item_t plan [$];
		int        n_items;
		int        planned;
		int        cost;
		int        left;
		int        random_done;
		int        count;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset stream length of one, then an item after the end
		send_item(header_item(16'sh7FFF, 8'd0));
		send_item(data_item(32'h12345678));

		// extremes of header and codes under the largest stream count
		load_sample_count(24'hFFFFFF);
		send_item(header_item(16'sh8000, 8'd255));
		send_item(data_item(32'hFFFFFFFF));
		send_item(header_item(16'sh7FFF, 8'd88));
		send_item(data_item(32'h77777777));
		send_item(header_item(16'sh0000, 8'd89));
		send_item(data_item(32'h88888888));
		send_item(header_item(16'sh0000, 8'd0));
		send_item(data_item(32'h00000000));
		send_item(data_item(32'h01234567));
		send_item(data_item(32'h89ABCDEF));
		send_item(header_item(16'sh1234, 8'h55));
		send_item(data_item(32'hA5A5A5A5));

		// zero count acts as one
		load_sample_count(24'd0);
		send_item(header_item(16'shC0DE, 8'd40));
		send_item(data_item(32'hFEDCBA98));

		// stream ends inside a word, later items dropped
		load_sample_count(24'd5);
		send_item(header_item(16'sh0100, 8'd20));
		send_item(data_item(32'h1F3C2A58));
		send_item(data_item(32'h76543210));
		send_item(header_item(16'sh2222, 8'd10));

		// random streams
		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			n_items = $urandom_range(3, 16);
			planned = 0;
			plan.delete();
			for (int k = 0; k < n_items; k++) begin
				if ((k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0)) begin
					plan.push_back(header_item(16'($urandom),
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
							: 8'($urandom_range(0, 88))));
					planned += 1;
				end else begin
					plan.push_back(data_item(random_word()));
					planned += 8;
				end
			end

			// mostly end within the last item, sometimes early or never
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: count = (planned > 8) ? planned - $urandom_range(0, 7) : planned;
				6, 7:             count = $urandom_range(1, planned);
				8:                count = 32'h800000;
				default:          count = $urandom_range(planned, 32'hFFFFFF);
			endcase
			load_sample_count(imadec_pkg::CNT_W'(count));
			left = count;

			foreach (plan[k]) begin
				cost = (plan[k].op == imadec_pkg::OP_HEADER) ? 1 : 8;
				if (left > 0) begin
					random_done++;
					left -= (cost > left) ? left : cost;
				end
				send_item(plan[k]);
				if ($urandom_range(0, 19) == 0)
					wait_drained();
			end

			// stray item after the end of the stream
			if (left == 0 && $urandom_range(0, 2) == 0)
				send_item(data_item(random_word()));
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && pending == 0)
			$display("ima_adpcm_block_decoder test passed");
		else
			$display("ima_adpcm_block_decoder test failed");
		$finish;
	end

endmodule

### filelist.f
src/imadec_pkg.sv
src/imadec_nibble.sv
src/ima_adpcm_block_decoder.sv
tb/imadec_checker.sv
tb/tb_top.sv
